/* hdl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants of the character LCD cursor byte engine.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int MAX_COLUMNS = 40;
	localparam int MAX_LINES   = 4;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] REG_LINES     = 2'd0;
	localparam logic [1:0] REG_COLUMNS   = 2'd1;
	localparam logic [1:0] REG_BACKLIGHT = 2'd2;

	localparam logic [7:0] CODE_CLEAR    = 8'h01;
	localparam logic [7:0] CODE_HOME     = 8'h02;
	localparam logic [7:0] CODE_SET_ADDR = 8'h80;
	localparam logic [7:0] NEWLINE_CODE  = 8'h0A;
	localparam logic [7:0] ROW_ODD_OFS   = 8'h40;

	// one or two controller bytes for the back end
	typedef struct packed {
		logic [7:0] b0;
		logic       sel0;
		logic       wait0;
		logic       two;
		logic [7:0] b1;
		logic       wait1;
	} job_t;

	typedef struct packed {
		logic [2:0] line_count;
		logic [5:0] column_count;
		logic       backlight;
	} cfg_t;

	function automatic logic [7:0] set_addr(input logic [5:0] col, input logic [1:0] row,
		input logic [5:0] cc);
		logic [7:0] a;
		a = {2'b00, col};
		if (row[0])
			a = a + ROW_ODD_OFS;
		if (row[1])
			a = a + {2'b00, cc};
		return CODE_SET_ADDR | a;
	endfunction

endpackage

/* hdl/char_lcd_cursor_byte_engine_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_cursor_byte_engine_top
// The first byte of an item passes the job queue and the sequencer's job and
// output registers. One byte per cycle goes out while jobs wait and out_ready
// allows; a printable character or clear makes 8 bytes, a newline or move 4,
// an unused command none. A 4-entry job queue takes items while bytes drain.
// Reset: config to 2 lines, 16 columns, backlight on; cursor home; queue empty.
// ----------------------------------------------------------------------------
module char_lcd_cursor_byte_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [5:0] column,
	input  logic [1:0] row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] bus_byte,
	output logic       long_wait,
	output logic       last
);
	import clcd_pkg::*;

	cfg_t cfg;
	job_t push_job;
	job_t head;
	logic push;
	logic q_ready;
	logic q_valid;
	logic pop;

	clcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.char_code (char_code),
		.column    (column),
		.row       (row),
		.q_ready   (q_ready),
		.q_push    (push),
		.q_job     (push_job),
		.cfg       (cfg)
	);

	clcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_head    (head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bus_byte  (bus_byte),
		.long_wait (long_wait),
		.last      (last)
	);

	a_wait_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_wait |-> !bus_byte[0])
		else $error("long wait on a data byte");

	a_wait_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (long_wait || last) |-> !bus_byte[2])
		else $error("final byte carries enable");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_ready)
		else $error("job pushed into full queue");

	a_bl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cfg.backlight |-> !bus_byte[3])
		else $error("backlight bit set while disabled");

endmodule

/* hdl/clcd_front.sv */
// ----------------------------------------------------------------------------
// clcd_front
// Config registers, cursor tracking and command classification into jobs.
// ----------------------------------------------------------------------------
module clcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [7:0]          char_code,
	input  logic [5:0]          column,
	input  logic [1:0]          row,
	input  logic                q_ready,
	output logic                q_push,
	output clcd_pkg::job_t      q_job,
	output clcd_pkg::cfg_t      cfg
);
	import clcd_pkg::*;

	cfg_t       cfg_q;
	logic [6:0] col_q;
	logic [2:0] row_q;
	logic       imp_q;

	logic       accept;
	logic       is_nl;
	logic [6:0] col_a;
	logic       wrap;
	logic [6:0] col_n;
	logic [2:0] row_a;
	logic [2:0] row_n;
	logic       imp_n;
	logic [2:0] lc_sat;
	logic [5:0] cc_sat;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;
	assign cfg      = cfg_q;

	assign lc_sat = (cfg_data[2:0] > 3'(MAX_LINES)) ? 3'(MAX_LINES) : cfg_data[2:0];
	assign cc_sat = (cfg_data > 6'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_count   <= 3'd2;
			cfg_q.column_count <= 6'd16;
			cfg_q.backlight    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINES:     cfg_q.line_count   <= lc_sat;
				REG_COLUMNS:   cfg_q.column_count <= cc_sat;
				REG_BACKLIGHT: cfg_q.backlight    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		is_nl = (char_code == NEWLINE_CODE);
		if (is_nl)
			col_a = imp_q ? col_q : {1'b0, cfg_q.column_count};
		else
			col_a = col_q + 7'd1;
		wrap  = (col_a >= {1'b0, cfg_q.column_count});
		col_n = wrap ? 7'd0 : col_a;
		row_a = wrap ? row_q + 3'd1 : row_q;
		imp_n = wrap && !is_nl;
		row_n = (row_a >= cfg_q.line_count) ? 3'd0 : row_a;
	end

	always_comb begin
		q_push = 1'b0;
		q_job  = '0;
		case (cmd)
			CMD_PUT: begin
				q_push = accept;
				if (is_nl) begin
					q_job.b0 = set_addr(col_n[5:0], row_n[1:0], cfg_q.column_count);
				end else begin
					q_job.b0   = char_code;
					q_job.sel0 = 1'b1;
					q_job.two  = 1'b1;
					q_job.b1   = set_addr(col_n[5:0], row_n[1:0], cfg_q.column_count);
				end
			end
			CMD_MOVE: begin
				q_push   = accept;
				q_job.b0 = set_addr(column, row, cfg_q.column_count);
			end
			CMD_CLEAR: begin
				q_push      = accept;
				q_job.b0    = CODE_CLEAR;
				q_job.wait0 = 1'b1;
				q_job.two   = 1'b1;
				q_job.b1    = CODE_HOME;
				q_job.wait1 = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			imp_q <= 1'b0;
		end else if (accept) begin
			case (cmd)
				CMD_PUT: begin
					col_q <= col_n;
					row_q <= row_n;
					imp_q <= imp_n;
				end
				CMD_MOVE: begin
					col_q <= {1'b0, column};
					row_q <= {1'b0, row};
				end
				CMD_CLEAR: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* hdl/clcd_queue.sv */
// ----------------------------------------------------------------------------
// clcd_queue
// Small job FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module clcd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  clcd_pkg::job_t      push_job,
	output logic                ready,
	input  logic                pop,
	output logic                valid,
	output clcd_pkg::job_t      head
);
	import clcd_pkg::*;

	job_t           mem [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/clcd_back.sv */
// ----------------------------------------------------------------------------
// clcd_back
// Sequencer: each controller byte goes out as four expander bytes.
// ----------------------------------------------------------------------------
module clcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  clcd_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  clcd_pkg::job_t      q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          bus_byte,
	output logic                long_wait,
	output logic                last
);
	import clcd_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic       sub_q;
	logic [1:0] phase_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       owait_q;
	logic       olast_q;

	logic       advance;
	logic       done;
	logic [7:0] value;
	logic       sel;
	logic       wt;
	logic [3:0] nib;

	assign advance = busy_q && (!ovalid_q || out_ready);
	assign done    = (phase_q == 2'd3) && (sub_q || !job_q.two);
	assign q_pop   = q_valid && (!busy_q || (advance && done));

	assign value = sub_q ? job_q.b1 : job_q.b0;
	assign sel   = sub_q ? 1'b0 : job_q.sel0;
	assign wt    = sub_q ? job_q.wait1 : job_q.wait0;
	assign nib   = phase_q[1] ? value[3:0] : value[7:4];

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_head;
		if (advance) begin
			obyte_q <= {nib, cfg.backlight, !phase_q[0], 1'b0, sel};
			owait_q <= wt && (phase_q == 2'd3);
			olast_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			sub_q    <= 1'b0;
			phase_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q  <= 1'b1;
				sub_q   <= 1'b0;
				phase_q <= '0;
			end else if (advance) begin
				phase_q <= phase_q + 2'd1;
				if (done)
					busy_q <= 1'b0;
				else if (phase_q == 2'd3)
					sub_q <= 1'b1;
			end
			if (advance)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	assign bus_byte  = obyte_q;
	assign long_wait = owait_q;
	assign last      = olast_q;

endmodule

/* bench/lcd_byte_checker.sv */
// ----------------------------------------------------------------------------
// lcd_byte_checker
// Watches the config port and both item channels of the character LCD cursor
// byte engine, predicts the expander bytes of every accepted item from its
// own cursor and config state, and compares each output item in order.
// ----------------------------------------------------------------------------
module lcd_byte_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [5:0] column,
	input  logic [1:0] row,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] bus_byte,
	input  logic       long_wait,
	input  logic       last,
	output int         fail_count,
	output int         pending_count
);
	import clcd_pkg::*;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       long_wait;
		logic       last;
	} exp_byte_t;

	exp_byte_t  expected_bytes[$];

	logic [2:0] lines;
	logic [5:0] cols;
	logic       backlight;
	logic [6:0] cur_col;
	logic [2:0] cur_row;
	logic       implied_nl;

	task automatic push_ctrl_byte(input logic [7:0] value, input logic sel);
		logic hold;
		hold = !sel && (value <= 8'd3);
		expected_bytes.push_back('{{value[7:4], backlight, 1'b1, 1'b0, sel}, 1'b0, 1'b0});
		expected_bytes.push_back('{{value[7:4], backlight, 1'b0, 1'b0, sel}, 1'b0, 1'b0});
		expected_bytes.push_back('{{value[3:0], backlight, 1'b1, 1'b0, sel}, 1'b0, 1'b0});
		expected_bytes.push_back('{{value[3:0], backlight, 1'b0, 1'b0, sel}, hold, 1'b0});
	endtask

	task automatic push_cursor_addr();
		logic [7:0] addr;
		addr = {2'b00, cur_col[5:0]};
		if (cur_row[0])
			addr = addr + ROW_ODD_OFS;
		if (cur_row[1])
			addr = addr + {2'b00, cols};
		push_ctrl_byte(CODE_SET_ADDR | addr, 1'b0);
	endtask

	task automatic predict_bytes(input logic [1:0] c, input logic [7:0] ch,
		input logic [5:0] col, input logic [1:0] r);
		int        n0;
		exp_byte_t tail;
		n0 = expected_bytes.size();
		case (c)
			CMD_PUT: begin
				if (ch == NEWLINE_CODE) begin
					if (!implied_nl)
						cur_col = {1'b0, cols};
				end else begin
					push_ctrl_byte(ch, 1'b1);
					cur_col = cur_col + 7'd1;
				end
				if (cur_col >= {1'b0, cols}) begin
					cur_col    = '0;
					cur_row    = cur_row + 3'd1;
					implied_nl = (ch != NEWLINE_CODE);
				end else begin
					implied_nl = 1'b0;
				end
				if (cur_row >= lines)
					cur_row = '0;
				push_cursor_addr();
			end
			CMD_MOVE: begin
				cur_col = {1'b0, col};
				cur_row = {1'b0, r};
				push_cursor_addr();
			end
			CMD_CLEAR: begin
				push_ctrl_byte(CODE_CLEAR, 1'b0);
				push_ctrl_byte(CODE_HOME, 1'b0);
				cur_col = '0;
				cur_row = '0;
			end
			default: ;
		endcase
		if (expected_bytes.size() > n0) begin
			tail      = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		exp_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			lines         = 3'd2;
			cols          = 6'd16;
			backlight     = 1'b1;
			cur_col       = '0;
			cur_row       = '0;
			implied_nl    = 1'b0;
			fail_count    = 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LINES:
						lines = (cfg_data[2:0] > MAX_LINES) ? 3'(MAX_LINES) : cfg_data[2:0];
					REG_COLUMNS:
						cols = (cfg_data > MAX_COLUMNS) ? 6'(MAX_COLUMNS) : cfg_data;
					REG_BACKLIGHT:
						backlight = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("bus_byte: unexpected item 0x%02h, nothing expected", bus_byte);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (bus_byte !== want.bus_byte) begin
						$error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, bus_byte);
						fail_count++;
					end
					if (long_wait !== want.long_wait) begin
						$error("long_wait: expected %0b, got %0b", want.long_wait, long_wait);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_bytes(cmd, char_code, column, row);
			pending_count <= expected_bytes.size();
		end
	end

endmodule

/* bench/char_lcd_cursor_byte_engine_top_test.sv */
// ----------------------------------------------------------------------------
// char_lcd_cursor_byte_engine_top_test
// Drives put, move, clear and unused requests into the LCD cursor byte engine
// under several line, column and backlight settings, with random idle bursts
// on both channels; a side checker predicts and compares every expander byte.
// ----------------------------------------------------------------------------
module char_lcd_cursor_byte_engine_top_test;
	import clcd_pkg::*;

	localparam logic [1:0] CMD_UNUSED     = 2'd3;
	localparam int         SETTLE_CYCLES  = 20;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         PHASE_ITEMS    = 34;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	logic [7:0] char_code;
	logic [5:0] column;
	logic [1:0] row;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] bus_byte;
	logic       long_wait;
	logic       last;

	int fail_count;
	int pending_count;
	int idle_pct;
	int idle_cycles;
	int cur_lines;
	int cur_cols;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_lcd_cursor_byte_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.char_code (char_code),
		.column    (column),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bus_byte  (bus_byte),
		.long_wait (long_wait),
		.last      (last)
	);

	lcd_byte_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.char_code     (char_code),
		.column        (column),
		.row           (row),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bus_byte      (bus_byte),
		.long_wait     (long_wait),
		.last          (last),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] c, input logic [7:0] ch,
		input logic [5:0] col, input logic [1:0] r);
		in_valid  <= 1'b1;
		cmd       <= c;
		char_code <= ch;
		column    <= col;
		row       <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic put_char(input logic [7:0] ch);
		send_item(CMD_PUT, ch, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
	endtask

	task automatic drain_bytes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int lines, input int cols, input int bl);
		drain_bytes();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LINES;
		cfg_data  <= 6'(lines);
		@(posedge clk);
		cfg_index <= REG_COLUMNS;
		cfg_data  <= 6'(cols);
		@(posedge clk);
		cfg_index <= REG_BACKLIGHT;
		cfg_data  <= 6'(bl);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_lines = (lines > MAX_LINES) ? MAX_LINES : lines;
		cur_cols  = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
	endtask

	task automatic send_random();
		int pick;
		int col_hi;
		int row_hi;
		pick   = $urandom_range(0, 99);
		col_hi = (cur_cols > 0) ? cur_cols - 1 : 0;
		row_hi = (cur_lines > 0) ? cur_lines - 1 : 0;
		if (pick < 55)
			put_char(8'($urandom_range(8'h20, 8'h7e)));
		else if (pick < 70)
			put_char(NEWLINE_CODE);
		else if (pick < 78)
			put_char(8'($urandom_range(0, 255)));
		else if (pick < 92) begin
			if ($urandom_range(0, 3) == 0)
				send_item(CMD_MOVE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
					2'($urandom_range(0, 3)));
			else
				send_item(CMD_MOVE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, col_hi)),
					2'($urandom_range(0, row_hi)));
		end else if (pick < 97)
			send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
				2'($urandom_range(0, 3)));
		else
			send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
				2'($urandom_range(0, 3)));
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LINES;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		cmd       <= CMD_PUT;
		char_code <= '0;
		column    <= '0;
		row       <= '0;
		idle_pct  = 30;
		idle_cycles = 0;
		cur_lines = 2;
		cur_cols  = 16;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: 2 lines, 16 columns, backlight on
		send_item(CMD_CLEAR, 8'h00, 6'd0, 2'd0);
		put_char(8'h00);
		put_char(8'hff);
		put_char(NEWLINE_CODE);
		send_item(CMD_MOVE, 8'h00, 6'd15, 2'd1);
		put_char(8'h41);
		put_char(NEWLINE_CODE);  // absorbed after wrap
		put_char(NEWLINE_CODE);
		send_item(CMD_MOVE, 8'hff, 6'd63, 2'd3);
		put_char(8'h5a);
		send_item(CMD_MOVE, 8'h00, 6'd0, 2'd2);
		send_item(CMD_MOVE, 8'h00, 6'd0, 2'd3);
		send_item(CMD_UNUSED, 8'hff, 6'd63, 2'd3);
		put_char(8'haa);
		put_char(8'h55);
		send_item(CMD_CLEAR, 8'hff, 6'd63, 2'd3);

		set_config(0, 0, 0);
		put_char(8'h41);
		put_char(NEWLINE_CODE);
		send_item(CMD_MOVE, 8'h00, 6'd5, 2'd3);
		put_char(8'h42);

		set_config(7, 63, 1);
		send_item(CMD_MOVE, 8'h00, 6'd39, 2'd3);
		put_char(8'h7e);
		put_char(NEWLINE_CODE);
		send_item(CMD_UNUSED, 8'h00, 6'd0, 2'd0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: set_config(1, 1, 0);
				3: set_config(4, 40, 1);
				default: set_config($urandom_range(0, 7),
					($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(0, 63),
					$urandom_range(0, 1));
			endcase
			idle_pct = (phase == 2 || phase == 5) ? 0 : 30;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
		end

		drain_bytes();
		if (fail_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/clcd_pkg.sv
hdl/clcd_front.sv
hdl/clcd_queue.sv
hdl/clcd_back.sv
hdl/char_lcd_cursor_byte_engine_top.sv
bench/lcd_byte_checker.sv
bench/char_lcd_cursor_byte_engine_top_test.sv
